// ===== hw/rtl/mrd_pkg.sv =====
// Shared types and constants for the motion region direction unit.
// No dependencies.
`default_nettype none

package mrd_pkg;

  localparam int PIXEL_W       = 8;
  localparam int REGION_SIZE_W = 10;
  localparam int DIR_W         = 3;
  localparam int SUM_W         = 27;
  localparam int SUM_MAG_W     = SUM_W - 1;
  localparam int SUM_LIMIT     = 67108863;

  typedef logic [PIXEL_W-1:0]       pixel_t;
  typedef logic [REGION_SIZE_W-1:0] region_size_t;
  typedef logic [DIR_W-1:0]         dir_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam dir_t DIR_NONE      = 3'd0;
  localparam dir_t DIR_VERT_NEG  = 3'd1;
  localparam dir_t DIR_VERT_POS  = 3'd2;
  localparam dir_t DIR_HORIZ_POS = 3'd3;
  localparam dir_t DIR_HORIZ_NEG = 3'd4;

  // One pixel as it leaves the front stage
  typedef struct packed {
    logic   vert_en;
    logic   horiz_en;
    logic   last;
    pixel_t px;
    pixel_t left;
  } s1_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mrd_pixel_if.sv =====
// Pixel request channel: valid/ready plus one region pixel.
// Depends on mrd_pkg.
`default_nettype none

interface mrd_pixel_if import mrd_pkg::*;;
  logic         valid;
  logic         ready;
  pixel_t       pixel;
  region_size_t region_width;
  region_size_t region_height;
  logic         last;

  modport source (output valid, pixel, region_width, region_height, last, input ready);
  modport sink   (input valid, pixel, region_width, region_height, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mrd_result_if.sv =====
// Result request channel: valid/ready plus direction and both sums.
// Depends on mrd_pkg.
`default_nettype none

interface mrd_result_if import mrd_pkg::*;;
  logic valid;
  logic ready;
  dir_t direction;
  sum_t vertical_sum;
  sum_t horizontal_sum;

  modport source (output valid, direction, vertical_sum, horizontal_sum, input ready);
  modport sink   (input valid, direction, vertical_sum, horizontal_sum, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mrd_front.sv =====
// Front stage: size clamping, column/row tracking, line buffer and area.
// Depends on mrd_pkg and mrd_pixel_if.
`default_nettype none

module mrd_front import mrd_pkg::*; #(
  parameter int MAX_W = 512,
  parameter int MAX_H = 512,
  localparam int WW = $clog2(MAX_W + 1),
  localparam int HW = $clog2(MAX_H + 1),
  localparam int AW = WW + HW
) (
  input  logic          clk,
  input  logic          rst,
  mrd_pixel_if.sink     pix,
  input  logic          s1_adv,
  output logic          s1_valid,
  output s1_t           s1,
  output pixel_t        s1_up,
  output logic [AW-1:0] s1_area
);

  localparam int CW  = $clog2(MAX_W);
  localparam int RW  = $clog2(MAX_H);
  localparam int SZW = (WW > REGION_SIZE_W) ? WW : REGION_SIZE_W;
  localparam int SZH = (HW > REGION_SIZE_W) ? HW : REGION_SIZE_W;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  pixel_t        prev_pixel;
  pixel_t        line_mem [MAX_W];
  pixel_t        up_q;

  logic [SZW-1:0] w_raw;
  logic [SZH-1:0] h_raw;
  logic [WW-1:0]  w_cl;
  logic [HW-1:0]  h_cl;
  logic           accept;
  logic           c_wrap;
  logic           row_top;
  logic           r_top;
  logic           col_end;
  logic [CW-1:0]  c;
  logic [RW-1:0]  r;
  logic [HW-1:0]  r_plus;
  logic           vert_en;
  logic           horiz_en;

  assign accept    = pix.valid && pix.ready;
  assign pix.ready = !s1_valid || s1_adv;

  assign w_raw = SZW'(pix.region_width);
  assign h_raw = SZH'(pix.region_height);

  always_comb begin
    priority if (w_raw == '0) begin
      w_cl = WW'(1);
    end else if (w_raw > SZW'(MAX_W)) begin
      w_cl = WW'(MAX_W);
    end else begin
      w_cl = WW'(w_raw);
    end
    priority if (h_raw == '0) begin
      h_cl = HW'(1);
    end else if (h_raw > SZH'(MAX_H)) begin
      h_cl = HW'(MAX_H);
    end else begin
      h_cl = HW'(h_raw);
    end
  end

  // A narrowed width can leave the counter past the row end: start a new row
  assign c_wrap  = WW'(column_count) >= w_cl;
  assign row_top = row_count == RW'(MAX_H - 1);
  assign c       = c_wrap ? '0 : column_count;
  assign r       = (c_wrap && !row_top) ? row_count + RW'(1) : row_count;
  assign r_top   = r == RW'(MAX_H - 1);
  assign col_end = (WW'(c) + WW'(1)) >= w_cl;
  assign r_plus  = HW'(r) + HW'(1);

  assign vert_en  = (r != '0) && (r_plus <= h_cl) && !col_end;
  assign horiz_en = (c != '0) && (r_plus < h_cl);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      prev_pixel   <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (accept) begin
        if (pix.last) begin
          column_count <= '0;
          row_count    <= '0;
          prev_pixel   <= '0;
        end else begin
          prev_pixel <= pix.pixel;
          if (col_end) begin
            column_count <= '0;
            row_count    <= r_top ? r : r + RW'(1);
          end else begin
            column_count <= c + CW'(1);
            row_count    <= r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.vert_en  <= vert_en;
      s1.horiz_en <= horiz_en;
      s1.last     <= pix.last;
      s1.px       <= pix.pixel;
      s1.left     <= prev_pixel;
      s1_area     <= AW'(w_cl) * AW'(h_cl);
    end
  end

  // Read-before-write: the entry above comes out before this pixel replaces it
  always_ff @(posedge clk) begin
    if (accept) begin
      up_q         <= line_mem[c];
      line_mem[c]  <= pix.pixel;
    end
  end

  assign s1_up = up_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mrd_accum.sv =====
// Saturating vertical and horizontal difference accumulators.
// Depends on mrd_pkg.
`default_nettype none

module mrd_accum import mrd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   s1_adv,
  input  s1_t    s1,
  input  pixel_t s1_up,
  output sum_t   v_next,
  output sum_t   h_next
);

  localparam logic signed [SUM_W:0] POS_LIM = (SUM_W + 1)'(SUM_LIMIT);
  localparam logic signed [SUM_W:0] NEG_LIM = -POS_LIM;

  sum_t vert_acc;
  sum_t horiz_acc;

  function automatic sum_t sat_add(input sum_t acc, input pixel_t a, input pixel_t b);
    logic signed [PIXEL_W:0] d;
    logic signed [SUM_W:0]   s;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    s = $signed({acc[SUM_W-1], acc}) + $signed({{(SUM_W - PIXEL_W){d[PIXEL_W]}}, d});
    if (s > POS_LIM) begin
      s = POS_LIM;
    end else if (s < NEG_LIM) begin
      s = NEG_LIM;
    end
    return s[SUM_W-1:0];
  endfunction

  always_comb begin
    v_next = vert_acc;
    h_next = horiz_acc;
    if (s1.vert_en && s1_up != '0 && s1.px != '0) begin
      v_next = sat_add(vert_acc, s1_up, s1.px);
    end
    if (s1.horiz_en && s1.left != '0 && s1.px != '0) begin
      h_next = sat_add(horiz_acc, s1.left, s1.px);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_acc  <= '0;
      horiz_acc <= '0;
    end else if (s1_adv) begin
      vert_acc  <= s1.last ? '0 : v_next;
      horiz_acc <= s1.last ? '0 : h_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mrd_decide.sv =====
// Final-sum register, threshold decision and output register.
// Depends on mrd_pkg and mrd_result_if.
`default_nettype none

module mrd_decide import mrd_pkg::*; #(
  parameter int AW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fin_load,
  input  sum_t          v_next,
  input  sum_t          h_next,
  input  logic [AW-1:0] area,
  output logic          fin_free,
  mrd_result_if.source  res
);

  localparam int SCW  = SUM_MAG_W + 4;
  localparam int CMPW = (AW > SCW) ? AW : SCW;

  logic          fin_valid;
  sum_t          fin_v;
  sum_t          fin_h;
  logic [AW-1:0] fin_area;

  logic                 fin_adv;
  logic [SUM_MAG_W-1:0] mag_v;
  logic [SUM_MAG_W-1:0] mag_h;
  logic                 vert_pick;
  logic [SUM_MAG_W-1:0] sel_mag;
  logic                 sel_neg;
  logic [CMPW-1:0]      scaled;
  logic                 over;
  dir_t                 dir;

  assign fin_adv  = fin_valid && (!res.valid || res.ready);
  assign fin_free = !fin_valid || fin_adv;

  assign mag_v     = fin_v[SUM_W-1] ? SUM_MAG_W'(-fin_v) : SUM_MAG_W'(fin_v);
  assign mag_h     = fin_h[SUM_W-1] ? SUM_MAG_W'(-fin_h) : SUM_MAG_W'(fin_h);
  assign vert_pick = mag_v > mag_h;
  assign sel_mag   = vert_pick ? mag_v : mag_h;
  assign sel_neg   = vert_pick ? fin_v[SUM_W-1] : fin_h[SUM_W-1];

  // |sum| > floor(area/10) exactly when 10*|sum| > area
  assign scaled = CMPW'({sel_mag, 3'b000}) + CMPW'({sel_mag, 1'b0});
  assign over   = scaled > CMPW'(fin_area);

  always_comb begin
    dir = DIR_NONE;
    if (over) begin
      if (vert_pick) begin
        dir = sel_neg ? DIR_VERT_NEG : DIR_VERT_POS;
      end else begin
        dir = sel_neg ? DIR_HORIZ_NEG : DIR_HORIZ_POS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (fin_load) begin
        fin_valid <= 1'b1;
      end else if (fin_adv) begin
        fin_valid <= 1'b0;
      end
      if (fin_adv) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_v    <= v_next;
      fin_h    <= h_next;
      fin_area <= area;
    end
    if (fin_adv) begin
      res.direction      <= dir;
      res.vertical_sum   <= fin_v;
      res.horizontal_sum <= fin_h;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/motion_region_direction_unit.sv =====
// Motion region direction unit: one region pixel per cycle, one result per region.
// A last pixel's result passes through the front-stage, final-sum and output registers in turn.
// Throughput: 1 pixel per cycle, set by the single-port line buffer read/write.
// Only a last pixel can stall, when the final-sum register and output register are full.
// Reset (rst, synchronous, active high) clears counters, sums and valids; line buffer is not cleared.
`default_nettype none

module motion_region_direction_unit import mrd_pkg::*; #(
  parameter int MAX_REGION_WIDTH  = 512,
  parameter int MAX_REGION_HEIGHT = 512
) (
  input logic          clk,
  input logic          rst,
  mrd_pixel_if.sink    pix,
  mrd_result_if.source res
);

  localparam int AW = $clog2(MAX_REGION_WIDTH + 1) + $clog2(MAX_REGION_HEIGHT + 1);

  // Front stage outputs
  logic          s1_valid;
  s1_t           s1;
  pixel_t        s1_up;
  logic [AW-1:0] s1_area;

  // Accumulator and decision stage handshake
  logic s1_adv;
  logic fin_free;
  logic fin_load;
  sum_t v_next;
  sum_t h_next;

  // An ordinary pixel always moves on; a last pixel needs room for its result
  assign s1_adv   = s1_valid && (!s1.last || fin_free);
  assign fin_load = s1_adv && s1.last;

  mrd_front #(
    .MAX_W (MAX_REGION_WIDTH),
    .MAX_H (MAX_REGION_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .s1_adv   (s1_adv),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_up    (s1_up),
    .s1_area  (s1_area)
  );

  mrd_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .s1_adv (s1_adv),
    .s1     (s1),
    .s1_up  (s1_up),
    .v_next (v_next),
    .h_next (h_next)
  );

  mrd_decide #(
    .AW (AW)
  ) u_decide (
    .clk      (clk),
    .rst      (rst),
    .fin_load (fin_load),
    .v_next   (v_next),
    .h_next   (h_next),
    .area     (s1_area),
    .fin_free (fin_free),
    .res      (res)
  );

  // Non-last pixels never hold off the input side
  a_no_stall_plain: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1.last |-> pix.ready)
    else $error("plain pixel stalled the input");

  // Vertical direction codes agree with the sign of the vertical sum
  a_vert_sign: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.direction == DIR_VERT_NEG || res.direction == DIR_VERT_POS) |->
      (res.direction == DIR_VERT_NEG) == res.vertical_sum[SUM_W-1])
    else $error("vertical direction disagrees with vertical sum sign");

  // Horizontal direction codes agree with the sign of the horizontal sum
  a_horiz_sign: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.direction == DIR_HORIZ_NEG || res.direction == DIR_HORIZ_POS) |->
      (res.direction == DIR_HORIZ_NEG) == res.horizontal_sum[SUM_W-1])
    else $error("horizontal direction disagrees with horizontal sum sign");

endmodule

`default_nettype wire

// ===== test/mrd_checker.sv =====
// Scoreboard for the motion region direction unit: follows accepted pixel requests,
// predicts the result of each region and compares it with the result channel.
// Depends on mrd_pkg, mrd_pixel_if and mrd_result_if.
`default_nettype none

module mrd_checker import mrd_pkg::*; #(
  parameter int MAX_W = 512,
  parameter int MAX_H = 512
) (
  input  logic  clk,
  input  logic  rst,
  mrd_pixel_if  pix,
  mrd_result_if res,
  output int    fails,
  output int    waiting
);

  typedef struct packed {
    dir_t direction;
    sum_t vertical_sum;
    sum_t horizontal_sum;
  } region_result_t;

  pixel_t         line_buf [MAX_W];
  pixel_t         left_px;
  int unsigned    col;
  int unsigned    row;
  longint         vert_sum;
  longint         horiz_sum;
  region_result_t region_results_q [$];
  region_result_t want;
  int             bad;

  function automatic longint clip_sum(input longint s);
    if (s > SUM_LIMIT) return SUM_LIMIT;
    if (s < -SUM_LIMIT) return -SUM_LIMIT;
    return s;
  endfunction

  // One pixel step; a last pixel closes the region and queues its result.
  task automatic accumulate_pixel(input pixel_t px, input region_size_t wf,
                                  input region_size_t hf, input logic is_last);
    int unsigned    w, h, c, r;
    longint         cur, up, lf, thr, vmag, hmag;
    region_result_t rr;
    w = (wf == 0) ? 1 : (wf > MAX_W) ? MAX_W : wf;
    h = (hf == 0) ? 1 : (hf > MAX_H) ? MAX_H : hf;
    c = col;
    r = row;
    cur = px;
    up = line_buf[c];
    lf = left_px;
    // column past a shrunken width wraps to a new row
    if (c >= w) begin
      c = 0;
      up = line_buf[0];
      if (r < MAX_H - 1) r++;
    end
    if (r >= 1 && r <= h - 1 && c < w - 1 && up != 0 && cur != 0)
      vert_sum = clip_sum(vert_sum + up - cur);
    if (c >= 1 && r < h - 1 && lf != 0 && cur != 0)
      horiz_sum = clip_sum(horiz_sum + lf - cur);
    line_buf[c] = px;
    left_px = px;
    if (c + 1 >= w) begin
      col = 0;
      row = (r < MAX_H - 1) ? r + 1 : r;
    end else begin
      col = c + 1;
      row = r;
    end
    if (is_last) begin
      thr = w * h / 10;
      vmag = (vert_sum < 0) ? -vert_sum : vert_sum;
      hmag = (horiz_sum < 0) ? -horiz_sum : horiz_sum;
      rr.direction = DIR_NONE;
      if (vmag > hmag) begin
        if (vert_sum > thr) rr.direction = DIR_VERT_POS;
        else if (vert_sum < -thr) rr.direction = DIR_VERT_NEG;
      end else begin
        if (horiz_sum > thr) rr.direction = DIR_HORIZ_POS;
        else if (horiz_sum < -thr) rr.direction = DIR_HORIZ_NEG;
      end
      rr.vertical_sum = vert_sum[SUM_W-1:0];
      rr.horizontal_sum = horiz_sum[SUM_W-1:0];
      region_results_q.push_back(rr);
      left_px = '0;
      col = 0;
      row = 0;
      vert_sum = 0;
      horiz_sum = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      left_px = '0;
      col = 0;
      row = 0;
      vert_sum = 0;
      horiz_sum = 0;
      bad = 0;
      region_results_q.delete();
    end else begin
      if (pix.valid && pix.ready)
        accumulate_pixel(pix.pixel, pix.region_width, pix.region_height, pix.last);
      if (res.valid && res.ready) begin
        if (region_results_q.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("unexpected result: direction %0d vertical %0d horizontal %0d",
                     res.direction, res.vertical_sum, res.horizontal_sum);
        end else begin
          want = region_results_q.pop_front();
          if (res.direction !== want.direction ||
              res.vertical_sum !== want.vertical_sum ||
              res.horizontal_sum !== want.horizontal_sum) begin
            bad++;
            if (bad <= 10)
              $display("result mismatch: direction exp %0d got %0d, vertical exp %0d got %0d, %s",
                       want.direction, res.direction, want.vertical_sum, res.vertical_sum,
                       $sformatf("horizontal exp %0d got %0d",
                                 want.horizontal_sum, res.horizontal_sum));
          end
        end
      end
    end
    // registered copies for the top
    fails <= bad;
    waiting <= region_results_q.size();
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Top of the motion region direction testbench: clock, reset, pixel stimulus,
// result back-pressure, watchdog and verdict.
// Depends on mrd_pkg, both channel interfaces, motion_region_direction_unit, mrd_checker.
`default_nettype none

module testbench;
  import mrd_pkg::*;

  localparam int MAX_W      = 512;
  localparam int MAX_H      = 512;
  // cycles with no request moving on either channel before the run is abandoned
  localparam int IDLE_LIMIT = 2000;

  // Pixel content of a region, as a function of its row and column.
  typedef enum int {
    PAT_NOISE,       // uniform 0..255, zeros included
    PAT_SPARSE,      // one in three zero, else random
    PAT_FALL_DOWN,   // brighter rows above: positive vertical sum
    PAT_RISE_DOWN,   // darker rows above: negative vertical sum
    PAT_FALL_RIGHT,  // brighter columns left: positive horizontal sum
    PAT_RISE_RIGHT,  // darker columns left: negative horizontal sum
    PAT_SLOPE,       // diagonal ramp: equal magnitudes on square regions
    PAT_CORNER,      // 3 in the first pixel, 1 elsewhere: sums of exactly 2
    PAT_DIAG         // 255,1,0 along diagonals: +254 every third pair, never cancels
  } fill_t;

  logic clk;
  logic rst;
  int   fails;
  int   waiting;
  int   pixels_sent;
  int   regions_sent;
  int   idle_cycles;
  bit   steady;        // no gaps and no stalls while set

  mrd_pixel_if  pix_ch ();
  mrd_result_if res_ch ();

  motion_region_direction_unit #(
    .MAX_REGION_WIDTH (MAX_W),
    .MAX_REGION_HEIGHT(MAX_H)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pix(pix_ch),
    .res(res_ch)
  );

  mrd_checker #(
    .MAX_W(MAX_W),
    .MAX_H(MAX_H)
  ) score (
    .clk    (clk),
    .rst    (rst),
    .pix    (pix_ch),
    .res    (res_ch),
    .fails  (fails),
    .waiting(waiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Region sides for random regions: small almost always, zero now and then.
  function automatic region_size_t pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return region_size_t'($urandom_range(1, 6));
    if (roll < 95) return region_size_t'($urandom_range(7, 24));
    return '0;
  endfunction

  function automatic pixel_t fill_pixel(input fill_t fill, input int r, input int c);
    case (fill)
      PAT_NOISE:      return pixel_t'($urandom_range(0, 255));
      PAT_SPARSE:     return ($urandom_range(0, 2) == 0) ? 8'd0 :
                             pixel_t'($urandom_range(1, 255));
      PAT_FALL_DOWN:  return pixel_t'(255 - 60 * (r % 4));
      PAT_RISE_DOWN:  return pixel_t'(1 + 60 * (r % 4));
      PAT_FALL_RIGHT: return pixel_t'(255 - 60 * (c % 4));
      PAT_RISE_RIGHT: return pixel_t'(1 + 60 * (c % 4));
      PAT_SLOPE:      return pixel_t'(255 - 60 * ((r + c) % 4));
      PAT_CORNER:     return (r == 0 && c == 0) ? 8'd3 : 8'd1;
      default: begin
        case ((r + c) % 3)
          0:       return 8'd255;
          1:       return 8'd1;
          default: return 8'd0;
        endcase
      end
    endcase
  endfunction

  // One pixel request. Valid goes up at a rising edge; ready is looked at on the
  // falling edge, where it has settled for the edge that follows.
  task automatic send_pixel(input pixel_t p, input region_size_t w,
                            input region_size_t h, input logic is_last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid         <= 1'b1;
    pix_ch.pixel         <= p;
    pix_ch.region_width  <= w;
    pix_ch.region_height <= h;
    pix_ch.last          <= is_last;
    @(negedge clk);
    while (!pix_ch.ready) @(negedge clk);
    @(posedge clk);
    pixels_sent++;
  endtask

  // A region of count pixels, last on the final one. Row and column for the fill
  // follow the clamped nominal width wf. With jitter, about one pixel in
  // four carries random size codes, so width can shrink or grow mid-row.
  task automatic send_region(input region_size_t wf, input region_size_t hf,
                             input int count, input fill_t fill, input bit jitter);
    int           cw, r, c, i;
    region_size_t w, h;
    cw = (wf == 0) ? 1 : (wf > MAX_W) ? MAX_W : wf;
    r = 0;
    c = 0;
    for (i = 0; i < count; i++) begin
      w = wf;
      h = hf;
      if (jitter && $urandom_range(0, 3) == 0) begin
        w = region_size_t'($urandom_range(0, 1023));
        h = region_size_t'($urandom_range(0, 1023));
      end
      send_pixel(fill_pixel(fill, r, c), w, h, i == count - 1);
      c++;
      if (c == cw) begin
        c = 0;
        r++;
      end
    end
    regions_sent++;
  endtask

  // Result side: ready drops for random stretches unless the run is in a steady phase.
  initial begin : result_sink
    int hold;
    forever begin
      hold = steady ? 0 : pick_gap();
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog: any request on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    region_size_t wf;
    region_size_t hf;
    int           area;
    int           kind;
    fill_t        fill;
    steady = 1'b0;
    rst <= 1'b1;
    pix_ch.valid         <= 1'b0;
    pix_ch.pixel         <= '0;
    pix_ch.region_width  <= 10'd1;
    pix_ch.region_height <= 10'd1;
    pix_ch.last          <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Oversized width code over a single row: every line buffer entry gets
    // written here, so later size changes never read a stale entry.
    send_region(10'd1023, 10'd1, MAX_W, PAT_NOISE, 1'b0);
    // zero width and height count as one
    send_region(10'd0, 10'd0, 1, PAT_NOISE, 1'b0);
    // one region per direction code
    send_region(10'd2, 10'd2, 4, PAT_FALL_DOWN, 1'b0);
    send_region(10'd3, 10'd4, 12, PAT_RISE_DOWN, 1'b0);
    send_region(10'd4, 10'd3, 12, PAT_FALL_RIGHT, 1'b0);
    send_region(10'd4, 10'd2, 8, PAT_RISE_RIGHT, 1'b0);
    // equal magnitudes: horizontal sum wins the tie
    send_region(10'd3, 10'd3, 9, PAT_SLOPE, 1'b0);
    // sum equal to width*height/10 stays none, one above it does not
    send_region(10'd2, 10'd10, 20, PAT_CORNER, 1'b0);
    send_region(10'd3, 10'd6, 18, PAT_CORNER, 1'b0);
    // single column and single row: the matching sums stay zero
    send_region(10'd1, 10'd6, 6, PAT_FALL_DOWN, 1'b0);
    send_region(10'd6, 10'd1, 6, PAT_FALL_RIGHT, 1'b0);
    // oversized sizes cut short by an early last pixel
    send_region(10'd700, 10'd600, 5, PAT_NOISE, 1'b0);
    // pixels past the nominal region area
    send_region(10'd3, 10'd2, 20, PAT_SPARSE, 1'b0);
    // width shrinking and growing mid-row
    send_region(10'd5, 10'd4, 20, PAT_SLOPE, 1'b1);

    // Random part: mostly well-formed regions with random content, some broken.
    // Counts carry on from the directed part, keeping the run near 700 pixels.
    while (pixels_sent < 700 || regions_sent < 24) begin
      steady = ($urandom_range(0, 9) == 0);
      wf = pick_size();
      hf = pick_size();
      area = (wf == 0 ? 1 : wf) * (hf == 0 ? 1 : hf);
      fill = fill_t'($urandom_range(0, PAT_DIAG));
      kind = $urandom_range(0, 9);
      case (kind)
        7:       send_region(wf, hf, $urandom_range(1, area + 10), fill, 1'b0);
        8:       send_region(wf, hf, area, fill, 1'b1);
        9:       send_region(region_size_t'($urandom_range(0, 1023)),
                             region_size_t'($urandom_range(0, 1023)),
                             $urandom_range(1, 8), PAT_NOISE, 1'b1);
        default: send_region(wf, hf, area, fill, 1'b0);
      endcase
    end
    steady = 1'b0;
    pix_ch.valid <= 1'b0;

    // Drain: wait for every queued result, then a few cycles for strays.
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/mrd_pkg.sv
hw/rtl/mrd_pixel_if.sv
hw/rtl/mrd_result_if.sv
hw/rtl/mrd_front.sv
hw/rtl/mrd_accum.sv
hw/rtl/mrd_decide.sv
hw/rtl/motion_region_direction_unit.sv
test/mrd_checker.sv
test/testbench.sv
